@@ rtl/bdar_pkg.sv @@
// shared types and constants for the button debounce and auto-repeat unit
// no dependencies; imported by the lane, merge and top-level modules
package bdar_pkg;

   localparam int FIELD_W = 13;   // width of the level and event masks
   localparam int COUNT_W = 4;
   localparam int HOLD_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD  = 2'd2;

   // register reset values
   localparam logic [COUNT_W-1:0] DEBOUNCE_LIMIT_RST = 4'd2;
   localparam logic [HOLD_W-1:0]  REPEAT_DELAY_RST   = 8'd20;
   localparam logic [HOLD_W-1:0]  REPEAT_PERIOD_RST  = 8'd10;

   typedef struct packed {
      logic [COUNT_W-1:0] debounce_limit;
      logic [HOLD_W-1:0]  repeat_delay;
      logic [HOLD_W-1:0]  repeat_period;
   } cfg_type;

   typedef struct packed {
      logic press;
      logic rpt;
   } lane_event_type;

endpackage

@@ rtl/button_debounce_auto_repeat_unit.sv @@
// top level of the button debounce and auto-repeat unit
// depends on bdar_pkg, bdar_lane and bdar_merge
//
// Each accepted request is one sample tick of all button levels (bit clear means pressed)
// and produces exactly one result holding a press mask and a repeat mask. Every button has
// its own lane with a debounce count, a hold counter and pressed/repeating flags, all
// updated in the cycle the request is accepted; a merge stage packs the lane events into
// a result register, loaded at the same clock edge as the lane state. One request per
// cycle is taken as long as the result side keeps up: req_stall is raised only
// while a result is waiting and rsp_stall is high. Registers (debounce limit, repeat delay,
// repeat period) are written over the csr_ port, which is always ready; indexes beyond the
// list are ignored. Lanes are built for the buttons below both NUM_BUTTONS and the 13-bit
// mask width; result bits without a lane read as zero.
module button_debounce_auto_repeat_unit
   import bdar_pkg::*;
#(
   parameter int NUM_BUTTONS = 13
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_W-1:0]    req_button_levels,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FIELD_W-1:0]    rsp_press_mask,
   output logic [FIELD_W-1:0]    rsp_repeat_mask,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type        cfg_ff, cfg_in;
   logic           step;
   lane_event_type lane_events [FIELD_W];

   // register file, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_LIMIT: cfg_in.debounce_limit = csr_data[COUNT_W-1:0];
            CSR_REPEAT_DELAY:   cfg_in.repeat_delay   = csr_data[HOLD_W-1:0];
            CSR_REPEAT_PERIOD:  cfg_in.repeat_period  = csr_data[HOLD_W-1:0];
            default:            cfg_in = cfg_ff;   // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit <= DEBOUNCE_LIMIT_RST;
         cfg_ff.repeat_delay   <= REPEAT_DELAY_RST;
         cfg_ff.repeat_period  <= REPEAT_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall only while the result register is full and not being drained
   assign req_stall = rsp_valid & rsp_stall;
   assign step      = req_valid & ~req_stall;

   // one lane per button
   for (genvar g = 0; g < FIELD_W; g++) begin : g_lane
      if (g < NUM_BUTTONS) begin : g_used
         bdar_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .step      (step),
            .down      (~req_button_levels[g]),
            .cfg       (cfg_ff),
            .event_out (lane_events[g])
         );
      end else begin : g_unused
         // no button here, no events
         assign lane_events[g] = '0;
      end
   end

   bdar_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (step),
      .lane_events     (lane_events),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_press_mask  (rsp_press_mask),
      .rsp_repeat_mask (rsp_repeat_mask)
   );

endmodule

@@ rtl/bdar_lane.sv @@
// one button lane: debounce count, hold counter, press and repeat events
// depends on bdar_pkg
module bdar_lane
   import bdar_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           down,
   input  cfg_type        cfg,
   output lane_event_type event_out
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic               pressed_ff, pressed_in;
   logic               repeating_ff, repeating_in;

   logic [COUNT_W-1:0] count_upd;
   logic [HOLD_W-1:0]  hold_upd;
   logic               pressed_upd;
   logic               repeating_upd;

   always_comb begin
      // count update
      count_upd     = count_ff;
      hold_upd      = hold_ff;
      pressed_upd   = pressed_ff;
      repeating_upd = repeating_ff;
      if (down) begin
         if (count_ff < cfg.debounce_limit) begin
            count_upd = count_ff + COUNT_W'(1);
         end else if (hold_ff != HOLD_MAX) begin
            hold_upd = hold_ff + HOLD_W'(1);
         end
      end else begin
         if (count_ff == '0) begin
            pressed_upd   = 1'b0;
            hold_upd      = '0;
            repeating_upd = 1'b0;
         end else begin
            count_upd = count_ff - COUNT_W'(1);
         end
      end

      // event evaluation on the updated state
      count_in     = count_upd;
      hold_in      = hold_upd;
      pressed_in   = pressed_upd;
      repeating_in = repeating_upd;
      event_out    = '0;
      if (count_upd == cfg.debounce_limit && !pressed_upd) begin
         pressed_in      = 1'b1;
         event_out.press = 1'b1;
      end else if (pressed_upd && hold_upd == cfg.repeat_delay && !repeating_upd) begin
         repeating_in  = 1'b1;
         hold_in       = '0;
         event_out.rpt = 1'b1;
      end else if (repeating_upd && hold_upd == cfg.repeat_period) begin
         hold_in       = '0;
         event_out.rpt = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hold_ff      <= '0;
         pressed_ff   <= 1'b0;
         repeating_ff <= 1'b0;
      end else if (step) begin
         count_ff     <= count_in;
         hold_ff      <= hold_in;
         pressed_ff   <= pressed_in;
         repeating_ff <= repeating_in;
      end
   end

endmodule

@@ rtl/bdar_merge.sv @@
// merges the lane events into the two result masks and holds the result register
// depends on bdar_pkg
module bdar_merge
   import bdar_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lane_event_type      lane_events [FIELD_W],
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FIELD_W-1:0]  rsp_press_mask,
   output logic [FIELD_W-1:0]  rsp_repeat_mask
);

   logic               valid_ff, valid_in;
   logic [FIELD_W-1:0] press_ff, press_in;
   logic [FIELD_W-1:0] rpt_ff, rpt_in;

   always_comb begin
      for (int i = 0; i < FIELD_W; i++) begin
         press_in[i] = lane_events[i].press;
         rpt_in[i]   = lane_events[i].rpt;
      end
      valid_in = load | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         press_ff <= press_in;
         rpt_ff   <= rpt_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_press_mask  = press_ff;
   assign rsp_repeat_mask = rpt_ff;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for button_debounce_auto_repeat_unit
// depends on bdar_pkg and the unit's rtl; holds its own lane predictor and a result checker
module testbench;
   import bdar_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES = 13;

   // index past the end of the register list, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic [FIELD_W-1:0] ALL_PRESSED  = '0;
   localparam logic [FIELD_W-1:0] ALL_RELEASED = '1;

   // press and repeat masks that one sample tick is expected to give
   typedef struct packed {
      logic [FIELD_W-1:0] press;
      logic [FIELD_W-1:0] rpt;
   } tick_events_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FIELD_W-1:0]    req_button_levels = '1;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [FIELD_W-1:0]    rsp_press_mask;
   logic [FIELD_W-1:0]    rsp_repeat_mask;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers, at their reset values
   logic [COUNT_W-1:0] cfg_limit  = DEBOUNCE_LIMIT_RST;
   logic [HOLD_W-1:0]  cfg_delay  = REPEAT_DELAY_RST;
   logic [HOLD_W-1:0]  cfg_period = REPEAT_PERIOD_RST;

   // predictor copy of the per-button lane state
   logic [COUNT_W-1:0] lane_count   [LANES];
   logic               lane_pressed [LANES];
   logic [HOLD_W-1:0]  lane_hold    [LANES];
   logic               lane_repeats [LANES];

   tick_events_type pending_events[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_press_events = 0;
   int n_repeat_events = 0;
   int n_reg_writes = 0;
   int n_errors = 0;

   button_debounce_auto_repeat_unit #(.NUM_BUTTONS(LANES)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_button_levels (req_button_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_press_mask    (rsp_press_mask),
      .rsp_repeat_mask   (rsp_repeat_mask),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // one sample tick of all lanes: count update first, then at most one event per lane
   function automatic tick_events_type debounce_tick(input logic [FIELD_W-1:0] levels);
      tick_events_type ev;
      bit down;
      ev = '0;
      for (int i = 0; i < LANES; i++) begin
         down = (levels[i] == 1'b0);
         if (down) begin
            if (lane_count[i] < cfg_limit) begin
               lane_count[i] = lane_count[i] + 1'b1;
            end else if (lane_hold[i] != HOLD_MAX) begin
               // hold counter sticks at its maximum
               lane_hold[i] = lane_hold[i] + 1'b1;
            end
         end else begin
            if (lane_count[i] == '0) begin
               lane_pressed[i] = 1'b0;
               lane_hold[i]    = '0;
               lane_repeats[i] = 1'b0;
            end else begin
               lane_count[i] = lane_count[i] - 1'b1;
            end
         end
         if (lane_count[i] == cfg_limit && !lane_pressed[i]) begin
            lane_pressed[i] = 1'b1;
            ev.press[i] = 1'b1;
         end else if (lane_pressed[i] && lane_hold[i] == cfg_delay && !lane_repeats[i]) begin
            // first repeat after the delay
            lane_repeats[i] = 1'b1;
            lane_hold[i] = '0;
            ev.rpt[i] = 1'b1;
         end else if (lane_repeats[i] && lane_hold[i] == cfg_period) begin
            lane_hold[i] = '0;
            ev.rpt[i] = 1'b1;
         end
      end
      return ev;
   endfunction

   task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                  input logic [FIELD_W-1:0] want);
      $display("[%0t] mismatch in %s: got %h, expected %h (result %0d)",
               $realtime, what, got, want, n_checked);
      n_errors++;
   endtask

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin
      tick_events_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected result press_mask", rsp_press_mask, '0);
         end else begin
            want = pending_events.pop_front();
            if (rsp_press_mask !== want.press) begin
               report_mismatch("press_mask", rsp_press_mask, want.press);
            end
            if (rsp_repeat_mask !== want.rpt) begin
               report_mismatch("repeat_mask", rsp_repeat_mask, want.rpt);
            end
            n_press_events  += $countones(want.press);
            n_repeat_events += $countones(want.rpt);
            n_checked++;
         end
      end
   end

   // one request; valid stays high from the previous request unless the sender idles
   task automatic send_request(input logic [FIELD_W-1:0] levels);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_button_levels <= levels;
      do @(posedge clock); while (req_stall);
      // accepted at this edge, so the tick happens now in the predictor too
      pending_events.push_back(debounce_tick(levels));
      n_requests++;
   endtask

   // sender stops and waits for every outstanding result before going on
   task automatic drain_results();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEBOUNCE_LIMIT: cfg_limit  = data[COUNT_W-1:0];
         CSR_REPEAT_DELAY:   cfg_delay  = data[HOLD_W-1:0];
         CSR_REPEAT_PERIOD:  cfg_period = data[HOLD_W-1:0];
         default: ;  // unmapped index, nothing changes
      endcase
      n_reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // short hand-picked sequences: defaults, zero limit, extremes, lowered limit, zero delay
   task automatic test_directed();
      // reset values: press lands on the second pressed tick
      repeat (3) send_request(ALL_PRESSED);
      repeat (3) send_request(ALL_RELEASED);
      drain_results();
      // zero limit reports the press on the very first tick
      write_register(CSR_DEBOUNCE_LIMIT, 8'h00);
      write_register(CSR_REPEAT_DELAY, 8'd1);
      write_register(CSR_REPEAT_PERIOD, 8'd1);
      repeat (2) send_request(ALL_PRESSED);
      send_request(ALL_RELEASED);
      drain_results();
      // top bits of the limit write are dropped, leaving 15; unmapped write ignored
      write_register(CSR_DEBOUNCE_LIMIT, 8'hFF);
      write_register(CSR_REPEAT_DELAY, 8'hFF);
      write_register(CSR_REPEAT_PERIOD, 8'hFF);
      write_register(CSR_UNMAPPED, 8'h01);
      repeat (6) send_request(13'h0AAA);
      drain_results();
      // limit lowered under the current count: hold advances, no fresh press
      write_register(CSR_DEBOUNCE_LIMIT, 8'd3);
      repeat (3) send_request(13'h0AAA);
      repeat (2) send_request(13'h1555);
      drain_results();
      // zero delay and period never fire a repeat
      write_register(CSR_DEBOUNCE_LIMIT, 8'd1);
      write_register(CSR_REPEAT_DELAY, 8'd0);
      write_register(CSR_REPEAT_PERIOD, 8'd0);
      repeat (3) send_request(ALL_PRESSED);
      drain_results();
   endtask

   // long hold until the hold counter saturates, then a delay of 255 catches it
   task automatic test_hold_saturation();
      write_register(CSR_DEBOUNCE_LIMIT, 8'd1);
      write_register(CSR_REPEAT_DELAY, 8'd0);
      write_register(CSR_REPEAT_PERIOD, 8'd0);
      repeat (262) send_request(ALL_PRESSED);
      drain_results();
      write_register(CSR_REPEAT_DELAY, 8'd255);
      write_register(CSR_REPEAT_PERIOD, 8'd1);
      repeat (4) send_request(ALL_PRESSED);
      repeat (3) send_request(ALL_RELEASED);
      drain_results();
   endtask

   // random but mostly realistic button traffic, fresh registers every chunk
   task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
      logic [FIELD_W-1:0] held;
      logic [FIELD_W-1:0] levels;
      int sent;
      int chunk;
      send_idle_pct = snd_pct;
      recv_stall_pct = rcv_pct;
      held = '0;
      sent = 0;
      while (sent < count) begin
         drain_results();
         case ($urandom_range(9))
            0: write_register(CSR_DEBOUNCE_LIMIT, 8'd0);
            1: write_register(CSR_DEBOUNCE_LIMIT, 8'd15);
            2: write_register(CSR_DEBOUNCE_LIMIT, CSR_DATA_W'($urandom_range(255)));
            default: write_register(CSR_DEBOUNCE_LIMIT, CSR_DATA_W'($urandom_range(1, 4)));
         endcase
         case ($urandom_range(9))
            0: write_register(CSR_REPEAT_DELAY, 8'd255);
            1: write_register(CSR_REPEAT_DELAY, CSR_DATA_W'($urandom_range(255)));
            default: write_register(CSR_REPEAT_DELAY, CSR_DATA_W'($urandom_range(1, 10)));
         endcase
         case ($urandom_range(9))
            0: write_register(CSR_REPEAT_PERIOD, 8'd255);
            1: write_register(CSR_REPEAT_PERIOD, CSR_DATA_W'($urandom_range(255)));
            default: write_register(CSR_REPEAT_PERIOD, CSR_DATA_W'($urandom_range(1, 6)));
         endcase
         if ($urandom_range(5) == 0) begin
            write_register(CSR_UNMAPPED, CSR_DATA_W'($urandom_range(255)));
         end
         chunk = $urandom_range(50, 80);
         repeat (chunk) begin
            // buttons change intent now and then; held stretches give repeats
            for (int b = 0; b < LANES; b++) begin
               if ($urandom_range(39) == 0) held[b] = ~held[b];
            end
            levels = ~held;
            if ($urandom_range(9) == 0) begin
               levels = FIELD_W'($urandom);  // pure noise
            end else if ($urandom_range(7) == 0) begin
               levels = levels ^ (13'h1 << $urandom_range(LANES - 1));  // contact bounce
            end
            send_request(levels);
            sent++;
         end
      end
      drain_results();
   endtask

   // run ends here if the unit hangs
   initial begin
      #2_000_000;
      $display("timeout after %0d requests, %0d results", n_requests, n_checked);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      for (int i = 0; i < LANES; i++) begin
         lane_count[i]   = '0;
         lane_pressed[i] = 1'b0;
         lane_hold[i]    = '0;
         lane_repeats[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_stall_pct = 57;
      test_directed();
      test_hold_saturation();
      test_random(200, 15, 57);
      test_random(200, 57, 15);
      test_random(180, 0, 0);

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_events.size() != 0) begin
         $display("%0d expected results never arrived", pending_events.size());
         n_errors++;
      end
      $display("covered %0d requests and %0d results with %0d presses, %0d repeats",
               n_requests, n_checked, n_press_events, n_repeat_events);
      $display("over %0d register writes, including zero, saturated and unmapped settings",
               n_reg_writes);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/bdar_pkg.sv
rtl/bdar_lane.sv
rtl/bdar_merge.sv
rtl/button_debounce_auto_repeat_unit.sv
tb/testbench.sv
